>>> rtl/core/vertex_face_adjacency_builder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex face adjacency builder
// Concurrent checks sampled on clock, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef VERTEX_FACE_ADJACENCY_BUILDER_MACROS_SVH
`define VERTEX_FACE_ADJACENCY_BUILDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VFAB_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VFAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/vfab_pkg.sv
// ----------------------------------------------------------------------------
// vfab_pkg
// Sizes, codes and controller/datapath interface types of the vertex face
// adjacency builder.
// ----------------------------------------------------------------------------
package vfab_pkg;

   localparam int MAX_VERTICES       = 1024;
   localparam int MAX_CORNER_ENTRIES = 4096;
   localparam int MAX_CORNERS        = 8;
   localparam int MIN_CORNERS        = 3;

   localparam int VERT_W    = $clog2(MAX_VERTICES);
   localparam int NV_W      = VERT_W + 1;
   localparam int ENTRY_AW  = $clog2(MAX_CORNER_ENTRIES);
   localparam int COUNT_W   = ENTRY_AW + 1;
   localparam int OFFSET_AW = $clog2(MAX_VERTICES + 1);
   localparam int FACE_W    = ENTRY_AW;
   localparam int PIF_W     = $clog2(MAX_CORNERS);

   // Field widths of the stream items and registers.
   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 13;
   localparam int VALUE_W     = 13;
   localparam int STAT_W      = 3;
   localparam int VT_W        = 11;
   localparam int CPF_W       = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_TOTAL     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNERS_PER_FACE = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR    = 3'd0,
      FUNC_APPEND   = 3'd1,
      FUNC_BUILD    = 3'd2,
      FUNC_READ_OFF = 3'd3,
      FUNC_READ_ADJ = 3'd4
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_VERTEX    = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_INDEX     = 3'd3,
      STAT_NOT_BUILT = 3'd4,
      STAT_PARTIAL   = 3'd5
   } stat_type;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_WIPE,
      OP_APP_WR,
      OP_SCAN,
      OP_DECIDE,
      OP_PREFIX,
      OP_SC_CUR,
      OP_SC_WR,
      OP_SEAL,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              chk_ok;
      logic              wipe_last;
      logic              scan_done;
      logic              build_err;
      logic              prefix_done;
      logic              at_count;
      logic              built;
   } dp_sts_type;

endpackage

>>> rtl/core/vertex_face_adjacency_builder.sv
// ----------------------------------------------------------------------------
// vertex_face_adjacency_builder
// Transposes a face-to-vertex corner list into per-vertex face lists in
// compressed row form by counting sort.
//
//   Channel  Direction  Contents
//   req_*    in         func, corner vertex, read index
//   rsp_*    out        value, status (one result per request)
//   csr_*    in         vertex total, corners per face
//
// A clear sweeps the count store. In a build the scatter pass reads the corner
// store and the cursor table in turn. After reset the count store is swept
// before req_tready rises.
// A result waits in the output register; the next request is taken meanwhile
// and stalls only when its own result is ready.
// ----------------------------------------------------------------------------
`include "vertex_face_adjacency_builder_macros.svh"

module vertex_face_adjacency_builder import vfab_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // corner_vertex [9:0], read_index [22:10]
   input  logic [FUNC_W-1:0]      req_tuser,  // func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // value [12:0]
   output logic [STAT_W-1:0]      rsp_tuser,  // status
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   op_type             dp_cmd;
   dp_sts_type         dp_sts;
   logic [VALUE_W-1:0] rsp_value;

   vfab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

   vfab_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts),
      .req_func   (req_tuser),
      .req_vertex (req_tdata[VERT_W-1:0]),
      .req_index  (req_tdata[VERT_W+INDEX_W-1:VERT_W]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_value);

   `VFAB_ASSERT_HOLDS(a_finish_slot_free, dp_cmd == OP_FINISH, !rsp_tvalid || rsp_tready, "result overwritten before transfer")
   `VFAB_ASSERT_NEXT(a_seal_sets_built, dp_cmd == OP_SEAL, dp_sts.built, "table not marked built after scatter")
   `VFAB_ASSERT_HOLDS(a_error_value_zero, rsp_tvalid && (rsp_tuser != STAT_OK), rsp_tdata == '0, "error result carries a value")

endmodule

>>> rtl/core/vfab_ram.sv
// ----------------------------------------------------------------------------
// vfab_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vfab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/vfab_ctrl.sv
// ----------------------------------------------------------------------------
// vfab_ctrl
// Sequencer of the adjacency builder: decodes each request and steps the
// datapath through the count sweep, append, read and build passes.
// ----------------------------------------------------------------------------
module vfab_ctrl import vfab_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output op_type     dp_cmd,
   input  dp_sts_type dp_sts
);

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_DISPATCH,
      ST_APP_RD,
      ST_APP_WR,
      ST_READ,
      ST_SCAN,
      ST_DECIDE,
      ST_PREFIX,
      ST_SC_RD,
      ST_SC_CUR,
      ST_SC_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      from_clear_ff, from_clear_in;

   always_comb begin
      state_in      = state_ff;
      from_clear_in = from_clear_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      dp_cmd        = OP_NONE;
      case (state_ff)
         ST_WIPE: begin
            dp_cmd = OP_WIPE;
            if (dp_sts.wipe_last) begin
               state_in = from_clear_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            dp_cmd        = OP_CHECK;
            from_clear_in = (dp_sts.func == FUNC_CLEAR);
            case (dp_sts.func)
               FUNC_CLEAR:                  state_in = ST_WIPE;
               FUNC_APPEND:                 state_in = dp_sts.chk_ok ? ST_APP_RD : ST_FINISH;
               FUNC_BUILD:                  state_in = ST_SCAN;
               FUNC_READ_OFF, FUNC_READ_ADJ: state_in = dp_sts.chk_ok ? ST_READ : ST_FINISH;
               default:                     state_in = ST_FINISH;
            endcase
         end
         ST_APP_RD: begin
            state_in = ST_APP_WR;
         end
         ST_APP_WR: begin
            dp_cmd   = OP_APP_WR;
            state_in = ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            dp_cmd = OP_SCAN;
            if (dp_sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            dp_cmd   = OP_DECIDE;
            state_in = dp_sts.build_err ? ST_FINISH : ST_PREFIX;
         end
         ST_PREFIX: begin
            dp_cmd = OP_PREFIX;
            if (dp_sts.prefix_done) begin
               state_in = ST_SC_RD;
            end
         end
         ST_SC_RD: begin
            if (dp_sts.at_count) begin
               dp_cmd   = OP_SEAL;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SC_CUR;
            end
         end
         ST_SC_CUR: begin
            dp_cmd   = OP_SC_CUR;
            state_in = ST_SC_WR;
         end
         ST_SC_WR: begin
            dp_cmd   = OP_SC_WR;
            state_in = ST_SC_RD;
         end
         ST_FINISH: begin
            // The result register must be empty or emptying this cycle.
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WIPE;
         rsp_valid_ff  <= 1'b0;
         from_clear_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         from_clear_ff <= from_clear_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/core/vfab_dp.sv
// ----------------------------------------------------------------------------
// vfab_dp
// Datapath of the adjacency builder: configuration, corner and count stores,
// offset and cursor tables, adjacency store, pass counters and result register.
// ----------------------------------------------------------------------------
module vfab_dp import vfab_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  op_type                dp_cmd,
   output dp_sts_type            dp_sts,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [VERT_W-1:0]     req_vertex,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [VALUE_W-1:0]    rsp_value,
   output logic [STAT_W-1:0]     rsp_status
);

   logic [VT_W-1:0]     vt_ff, vt_in;
   logic [CPF_W-1:0]    cpf_ff, cpf_in;
   logic                built_ff, built_in;
   logic [COUNT_W-1:0]  corner_count_ff, corner_count_in;
   logic [COUNT_W-1:0]  ptr_ff, ptr_in;
   logic [PIF_W-1:0]    pif_ff, pif_in;
   logic [FACE_W-1:0]   face_ff, face_in;
   logic [FACE_W-1:0]   face_total_ff, face_total_in;
   logic                bad_ff, bad_in;
   logic                chk_vld_ff, chk_vld_in;
   logic                pvld_ff, pvld_in;
   logic [VERT_W-1:0]   v_d_ff, v_d_in;
   logic [COUNT_W-1:0]  acc_ff, acc_in;
   logic [VERT_W-1:0]   vert_ff, vert_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [VERT_W-1:0]   vertex_ff, vertex_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   stat_type            stat_ff, stat_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   stat_type            rsp_status_ff, rsp_status_in;

   logic [NV_W-1:0]     nv;
   logic [PIF_W-1:0]    cpf_last;
   logic                pif_wrap;
   logic [PIF_W-1:0]    pif_next;
   logic [FACE_W-1:0]   face_next;
   stat_type            chk_code;
   logic                scan_issue;
   logic                prefix_issue;
   logic                prefix_done;

   logic                corner_we;
   logic [VERT_W-1:0]   corner_rd;
   logic                cnt_we;
   logic [VERT_W-1:0]   cnt_waddr;
   logic [COUNT_W-1:0]  cnt_wdata;
   logic [VERT_W-1:0]   cnt_raddr;
   logic [COUNT_W-1:0]  cnt_rd;
   logic                row_we;
   logic [OFFSET_AW-1:0] row_waddr;
   logic [COUNT_W-1:0]  row_wdata;
   logic [COUNT_W-1:0]  row_rd;
   logic                cur_we;
   logic [VERT_W-1:0]   cur_waddr;
   logic [COUNT_W-1:0]  cur_wdata;
   logic [COUNT_W-1:0]  cur_rd;
   logic                adj_we;
   logic [FACE_W-1:0]   adj_rd;

   // Effective vertex total and corners per face after clamping.
   assign nv = (vt_ff > VT_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : NV_W'(vt_ff);

   always_comb begin
      if (cpf_ff < CPF_W'(MIN_CORNERS)) begin
         cpf_last = PIF_W'(MIN_CORNERS - 1);
      end else if (cpf_ff > CPF_W'(MAX_CORNERS)) begin
         cpf_last = PIF_W'(MAX_CORNERS - 1);
      end else begin
         cpf_last = PIF_W'(cpf_ff - CPF_W'(1));
      end
   end

   // The face number follows the corner position through a wrapping counter.
   assign pif_wrap  = (pif_ff == cpf_last);
   assign pif_next  = pif_wrap ? '0 : pif_ff + PIF_W'(1);
   assign face_next = pif_wrap ? face_ff + FACE_W'(1) : face_ff;

   always_comb begin
      chk_code = STAT_OK;
      case (func_ff)
         FUNC_APPEND: begin
            if (NV_W'(vertex_ff) >= nv) begin
               chk_code = STAT_VERTEX;
            end else if (corner_count_ff >= COUNT_W'(MAX_CORNER_ENTRIES)) begin
               chk_code = STAT_FULL;
            end
         end
         FUNC_READ_OFF: begin
            if (!built_ff) begin
               chk_code = STAT_NOT_BUILT;
            end else if (index_ff > INDEX_W'(nv)) begin
               chk_code = STAT_INDEX;
            end
         end
         FUNC_READ_ADJ: begin
            // The last offset of a built table equals the corner count.
            if (!built_ff) begin
               chk_code = STAT_NOT_BUILT;
            end else if (index_ff >= corner_count_ff) begin
               chk_code = STAT_INDEX;
            end
         end
         default: begin
            chk_code = STAT_OK;
         end
      endcase
   end

   assign scan_issue   = (ptr_ff != corner_count_ff);
   assign prefix_issue = (ptr_ff != COUNT_W'(nv));
   assign prefix_done  = !prefix_issue && !pvld_ff;

   always_comb begin
      vt_in           = vt_ff;
      cpf_in          = cpf_ff;
      built_in        = built_ff;
      corner_count_in = corner_count_ff;
      ptr_in          = ptr_ff;
      pif_in          = pif_ff;
      face_in         = face_ff;
      face_total_in   = face_total_ff;
      bad_in          = bad_ff;
      chk_vld_in      = chk_vld_ff;
      pvld_in         = pvld_ff;
      v_d_in          = v_d_ff;
      acc_in          = acc_ff;
      vert_in         = vert_ff;
      func_in         = func_ff;
      vertex_in       = vertex_ff;
      index_in        = index_ff;
      stat_in         = stat_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_status_in   = rsp_status_ff;

      corner_we = 1'b0;
      cnt_we    = 1'b0;
      cnt_waddr = vertex_ff;
      cnt_wdata = cnt_rd + COUNT_W'(1);
      cnt_raddr = vertex_ff;
      row_we    = 1'b0;
      row_waddr = OFFSET_AW'(v_d_ff) + OFFSET_AW'(1);
      row_wdata = acc_ff + cnt_rd;
      cur_we    = 1'b0;
      cur_waddr = v_d_ff;
      cur_wdata = acc_ff;
      adj_we    = 1'b0;

      case (dp_cmd)
         OP_LOAD: begin
            func_in   = req_func;
            vertex_in = req_vertex;
            index_in  = req_index;
         end
         OP_CHECK: begin
            stat_in    = chk_code;
            ptr_in     = '0;
            pif_in     = '0;
            face_in    = '0;
            bad_in     = 1'b0;
            chk_vld_in = 1'b0;
            if (func_ff == FUNC_CLEAR) begin
               corner_count_in = '0;
               built_in        = 1'b0;
            end
            if (func_ff == FUNC_BUILD) begin
               built_in = 1'b0;
            end
         end
         OP_WIPE: begin
            cnt_we    = 1'b1;
            cnt_waddr = ptr_ff[VERT_W-1:0];
            cnt_wdata = '0;
            ptr_in    = ptr_ff + COUNT_W'(1);
         end
         OP_APP_WR: begin
            cnt_we          = 1'b1;
            corner_we       = 1'b1;
            corner_count_in = corner_count_ff + COUNT_W'(1);
            built_in        = 1'b0;
         end
         OP_SCAN: begin
            // Corner read is issued here and checked in the following cycle.
            chk_vld_in = scan_issue;
            if (scan_issue) begin
               ptr_in  = ptr_ff + COUNT_W'(1);
               pif_in  = pif_next;
               face_in = face_next;
            end
            if (chk_vld_ff && (NV_W'(corner_rd) >= nv)) begin
               bad_in = 1'b1;
            end
         end
         OP_DECIDE: begin
            // A partial last face outranks a stale vertex.
            if (pif_ff != '0) begin
               stat_in = STAT_PARTIAL;
            end else if (bad_ff) begin
               stat_in = STAT_VERTEX;
            end
            face_total_in = face_ff;
            ptr_in        = '0;
            acc_in        = '0;
            pif_in        = '0;
            face_in       = '0;
            pvld_in       = 1'b0;
            row_we        = 1'b1;
            row_waddr     = '0;
            row_wdata     = '0;
         end
         OP_PREFIX: begin
            cnt_raddr = ptr_ff[VERT_W-1:0];
            v_d_in    = ptr_ff[VERT_W-1:0];
            pvld_in   = prefix_issue;
            if (prefix_issue) begin
               ptr_in = ptr_ff + COUNT_W'(1);
            end
            if (pvld_ff) begin
               row_we = 1'b1;
               cur_we = 1'b1;
               acc_in = acc_ff + cnt_rd;
            end
            if (prefix_done) begin
               ptr_in = '0;
            end
         end
         OP_SC_CUR: begin
            vert_in = corner_rd;
         end
         OP_SC_WR: begin
            adj_we    = (cur_rd < COUNT_W'(MAX_CORNER_ENTRIES));
            cur_we    = 1'b1;
            cur_waddr = vert_ff;
            cur_wdata = cur_rd + COUNT_W'(1);
            ptr_in    = ptr_ff + COUNT_W'(1);
            pif_in    = pif_next;
            face_in   = face_next;
         end
         OP_SEAL: begin
            built_in = 1'b1;
            stat_in  = STAT_OK;
         end
         OP_FINISH: begin
            rsp_status_in = stat_ff;
            rsp_value_in  = '0;
            if (stat_ff == STAT_OK) begin
               case (func_ff)
                  FUNC_BUILD:    rsp_value_in = VALUE_W'(face_total_ff);
                  FUNC_READ_OFF: rsp_value_in = row_rd;
                  FUNC_READ_ADJ: rsp_value_in = VALUE_W'(adj_rd);
                  default:       rsp_value_in = '0;
               endcase
            end
         end
         default: begin
         end
      endcase

      // Register writes must arrive only while the block is idle; not enforced here.
      if (csr_we) begin
         built_in = 1'b0;
         case (csr_index)
            CSR_VERTEX_TOTAL:     vt_in  = VT_W'(csr_wdata);
            CSR_CORNERS_PER_FACE: cpf_in = csr_wdata[CPF_W-1:0];
            default:              vt_in  = vt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff           <= VT_W'(1);
         cpf_ff          <= CPF_W'(MIN_CORNERS);
         built_ff        <= 1'b0;
         corner_count_ff <= '0;
         ptr_ff          <= '0;
         chk_vld_ff      <= 1'b0;
         pvld_ff         <= 1'b0;
      end else begin
         vt_ff           <= vt_in;
         cpf_ff          <= cpf_in;
         built_ff        <= built_in;
         corner_count_ff <= corner_count_in;
         ptr_ff          <= ptr_in;
         chk_vld_ff      <= chk_vld_in;
         pvld_ff         <= pvld_in;
      end
   end

   always_ff @(posedge clock) begin
      pif_ff        <= pif_in;
      face_ff       <= face_in;
      face_total_ff <= face_total_in;
      bad_ff        <= bad_in;
      v_d_ff        <= v_d_in;
      acc_ff        <= acc_in;
      vert_ff       <= vert_in;
      func_ff       <= func_in;
      vertex_ff     <= vertex_in;
      index_ff      <= index_in;
      stat_ff       <= stat_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   vfab_ram #(.WIDTH(VERT_W), .DEPTH(MAX_CORNER_ENTRIES)) u_corner_store (
      .clock (clock),
      .we    (corner_we),
      .waddr (corner_count_ff[ENTRY_AW-1:0]),
      .wdata (vertex_ff),
      .raddr (ptr_ff[ENTRY_AW-1:0]),
      .rdata (corner_rd)
   );

   vfab_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_VERTICES)) u_vertex_counts (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rd)
   );

   vfab_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_VERTICES + 1)) u_row_offsets (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .raddr (index_ff[OFFSET_AW-1:0]),
      .rdata (row_rd)
   );

   vfab_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_VERTICES)) u_fill_cursors (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .raddr (corner_rd),
      .rdata (cur_rd)
   );

   vfab_ram #(.WIDTH(FACE_W), .DEPTH(MAX_CORNER_ENTRIES)) u_adjacency_store (
      .clock (clock),
      .we    (adj_we),
      .waddr (cur_rd[ENTRY_AW-1:0]),
      .wdata (face_ff),
      .raddr (index_ff[ENTRY_AW-1:0]),
      .rdata (adj_rd)
   );

   assign dp_sts.func        = func_ff;
   assign dp_sts.chk_ok      = (chk_code == STAT_OK);
   assign dp_sts.wipe_last   = (ptr_ff[VERT_W-1:0] == VERT_W'(MAX_VERTICES - 1));
   assign dp_sts.scan_done   = !scan_issue && !chk_vld_ff;
   assign dp_sts.build_err   = (pif_ff != '0) || bad_ff;
   assign dp_sts.prefix_done = prefix_done;
   assign dp_sts.at_count    = !scan_issue;
   assign dp_sts.built       = built_ff;

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> tb/sv/tb_vertex_face_adjacency_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex face adjacency builder testbench
// Streams face corners, build commands and table reads into the block and
// checks every reply against a predictor of the counting-sort transpose,
// with random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_vertex_face_adjacency_builder;
   import vfab_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
   localparam int STALL_LIMIT   = 100000;
   localparam int LONG_HOLD     = 400;
   localparam int REPORT_LIMIT  = 40;

   typedef struct {
      logic [FUNC_W-1:0]  code;
      logic [VALUE_W-1:0] value;
      logic [STAT_W-1:0]  status;
   } adj_reply_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]      rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   vertex_face_adjacency_builder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predicted state of the builder.
   int unsigned cfg_vertex_total     = 1;
   int unsigned cfg_corners_per_face = 3;
   int unsigned mesh_corners [MAX_CORNER_ENTRIES];
   int unsigned mesh_corner_count    = 0;
   int unsigned vertex_hits [MAX_VERTICES];
   int unsigned row_start [MAX_VERTICES+1];
   int unsigned face_of_slot [MAX_CORNER_ENTRIES];
   bit          table_ready          = 1'b0;

   adj_reply_type awaited_replies [$];
   int unsigned mismatch_count = 0;
   int unsigned sent_count     = 0;
   bit          tx_idle_on     = 1'b1;
   bit          rx_idle_on     = 1'b1;
   bit          hold_request   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned active_vertices();
      return (cfg_vertex_total < MAX_VERTICES) ? cfg_vertex_total : MAX_VERTICES;
   endfunction

   function automatic int unsigned active_corners();
      if (cfg_corners_per_face < MIN_CORNERS) return MIN_CORNERS;
      if (cfg_corners_per_face > MAX_CORNERS) return MAX_CORNERS;
      return cfg_corners_per_face;
   endfunction

   function automatic adj_reply_type predict_adjacency_reply(input logic [FUNC_W-1:0] code,
         input logic [VERT_W-1:0] vtx, input logic [INDEX_W-1:0] idx);
      adj_reply_type r;
      int unsigned nv;
      int unsigned cpf;
      int unsigned pos;
      bit          stray;
      int unsigned cursor [MAX_VERTICES];
      r.code   = code;
      r.value  = '0;
      r.status = STAT_OK;
      nv       = active_vertices();
      cpf      = active_corners();
      case (code)
         FUNC_CLEAR: begin
            mesh_corner_count = 0;
            foreach (vertex_hits[v]) vertex_hits[v] = 0;
            table_ready = 1'b0;
         end
         FUNC_APPEND: begin
            // The vertex range is checked ahead of the capacity.
            if (vtx >= nv) begin
               r.status = STAT_VERTEX;
            end else if (mesh_corner_count >= MAX_CORNER_ENTRIES) begin
               r.status = STAT_FULL;
            end else begin
               mesh_corners[mesh_corner_count] = vtx;
               mesh_corner_count++;
               vertex_hits[vtx]++;
               table_ready = 1'b0;
            end
         end
         FUNC_BUILD: begin
            table_ready = 1'b0;
            stray = 1'b0;
            for (int i = 0; i < mesh_corner_count; i++)
               if (mesh_corners[i] >= nv) stray = 1'b1;
            if (mesh_corner_count % cpf != 0) begin
               r.status = STAT_PARTIAL;
            end else if (stray) begin
               r.status = STAT_VERTEX;
            end else begin
               row_start[0] = 0;
               for (int v = 0; v < nv; v++) row_start[v+1] = row_start[v] + vertex_hits[v];
               for (int v = 0; v < nv; v++) cursor[v] = row_start[v];
               // Scattering in corner order leaves every vertex's faces ascending.
               for (int i = 0; i < mesh_corner_count; i++) begin
                  pos = cursor[mesh_corners[i]];
                  if (pos < MAX_CORNER_ENTRIES) face_of_slot[pos] = i / cpf;
                  cursor[mesh_corners[i]] = pos + 1;
               end
               table_ready = 1'b1;
               r.value = VALUE_W'(mesh_corner_count / cpf);
            end
         end
         FUNC_READ_OFF: begin
            if (!table_ready) r.status = STAT_NOT_BUILT;
            else if (idx > nv) r.status = STAT_INDEX;
            else r.value = VALUE_W'(row_start[idx]);
         end
         FUNC_READ_ADJ: begin
            if (!table_ready) r.status = STAT_NOT_BUILT;
            else if (idx >= row_start[nv] || idx >= MAX_CORNER_ENTRIES) r.status = STAT_INDEX;
            else r.value = VALUE_W'(face_of_slot[idx]);
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offers one request, idling first now and then, and books its reply on transfer.
   task automatic send_request(input logic [FUNC_W-1:0] code, input logic [VERT_W-1:0] vtx,
         input logic [INDEX_W-1:0] idx);
      int gap;
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {1'b0, idx, vtx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_replies.push_back(predict_adjacency_reply(code, vtx, idx));
      sent_count++;
   endtask

   // Stops offering and waits until every booked reply has come back.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] sel,
         input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      if (sel == CSR_VERTEX_TOTAL) cfg_vertex_total = data;
      else cfg_corners_per_face = data[CPF_W-1:0];
      table_ready = 1'b0;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_corners();
      // Reset leaves one vertex and three corners per face.
      send_request(FUNC_READ_OFF, 0, 0);
      send_request(FUNC_READ_ADJ, 0, 0);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_READ_OFF, 0, 1);
      send_request(FUNC_READ_OFF, 0, 2);
      send_request(FUNC_READ_ADJ, 0, 0);
      send_request(FUNC_APPEND, 1, 0);
      send_request(FUNC_APPEND, 0, 0);
      send_request(FUNC_APPEND, 0, 0);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_APPEND, 0, 0);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_READ_ADJ, 0, 2);
      send_request(FUNC_READ_ADJ, 0, 3);
      send_request(FUNC_READ_OFF, 0, 1);
      for (int c = FUNC_SPARE_FIRST; c <= FUNC_SPARE_LAST; c++)
         send_request(FUNC_W'(c), '1, '1);
      send_request(FUNC_CLEAR, 0, 0);
      send_request(FUNC_READ_OFF, 0, 0);
      drain_replies();
   endtask

   task automatic test_register_limits();
      // An oversized total acts as the full vertex range, zero corners as three.
      write_register(CSR_VERTEX_TOTAL, 11'd2047);
      write_register(CSR_CORNERS_PER_FACE, 11'd0);
      send_request(FUNC_APPEND, 10'd1023, 0);
      send_request(FUNC_APPEND, 10'd0, 0);
      send_request(FUNC_APPEND, 10'h2AA, 0);
      send_request(FUNC_APPEND, 10'h155, 0);
      send_request(FUNC_APPEND, 10'd1023, 0);
      send_request(FUNC_APPEND, 10'd0, 0);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_READ_OFF, 0, MAX_VERTICES);
      send_request(FUNC_READ_OFF, 0, MAX_VERTICES + 1);
      send_request(FUNC_READ_OFF, 0, MAX_VERTICES - 1);
      send_request(FUNC_READ_ADJ, 0, 5);
      send_request(FUNC_READ_ADJ, 0, 13'h1FFF);
      drain_replies();
      // A register write drops the table; a smaller total then strands corners.
      write_register(CSR_VERTEX_TOTAL, 11'd5);
      send_request(FUNC_READ_ADJ, 0, 0);
      send_request(FUNC_BUILD, 0, 0);
      drain_replies();
      write_register(CSR_VERTEX_TOTAL, 11'd0);
      send_request(FUNC_CLEAR, 0, 0);
      send_request(FUNC_APPEND, 0, 0);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_READ_OFF, 0, 0);
      send_request(FUNC_READ_OFF, 0, 1);
      drain_replies();
      // Anything above the largest face size acts as eight corners.
      write_register(CSR_VERTEX_TOTAL, 11'd1024);
      write_register(CSR_CORNERS_PER_FACE, 11'd15);
      for (int i = 0; i < 8; i++) send_request(FUNC_APPEND, (i * 3) % 4, 0);
      send_request(FUNC_BUILD, 0, 0);
      for (int i = 0; i < 4; i++) send_request(FUNC_READ_OFF, 0, i);
      send_request(FUNC_READ_ADJ, 0, 7);
      drain_replies();
      write_register(CSR_CORNERS_PER_FACE, 11'd8);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_READ_ADJ, 0, 3);
      drain_replies();
   endtask

   task automatic test_output_backpressure();
      hold_request = 1'b1;
      write_register(CSR_CORNERS_PER_FACE, 11'd4);
      send_request(FUNC_CLEAR, 0, 0);
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 2) send_request(FUNC_READ_OFF, 0, $urandom_range(0, 8191));
         else send_request(FUNC_APPEND, $urandom_range(0, 1023), 0);
      end
      send_request(FUNC_BUILD, 0, 0);
      drain_replies();
   endtask

   task automatic test_store_full();
      write_register(CSR_VERTEX_TOTAL, 11'd1000);
      write_register(CSR_CORNERS_PER_FACE, 11'd8);
      send_request(FUNC_CLEAR, 0, 0);
      for (int i = 0; i < MAX_CORNER_ENTRIES; i++)
         send_request(FUNC_APPEND, $urandom_range(0, 999), 0);
      send_request(FUNC_APPEND, 1010, 0);
      send_request(FUNC_APPEND, 5, 0);
      send_request(FUNC_BUILD, 0, 0);
      send_request(FUNC_READ_OFF, 0, 1000);
      send_request(FUNC_READ_ADJ, 0, MAX_CORNER_ENTRIES - 1);
      send_request(FUNC_READ_ADJ, 0, MAX_CORNER_ENTRIES);
      for (int i = 0; i < 8; i++)
         send_request(FUNC_READ_ADJ, 0, $urandom_range(0, MAX_CORNER_ENTRIES - 1));
      send_request(FUNC_CLEAR, 0, 0);
      drain_replies();
   endtask

   task automatic test_random_meshes(input int unsigned budget);
      int unsigned first;
      int unsigned nv;
      int unsigned corners;
      int unsigned top;
      int unsigned idx;
      int unsigned reads;
      logic [VERT_W-1:0] vtx;
      bit          last_stretch;
      first = sent_count;
      while (sent_count - first < budget) begin
         last_stretch = (sent_count - first) > (budget * 4) / 5;
         drain_replies();
         tx_idle_on = !last_stretch && $urandom_range(0, 2) != 0;
         rx_idle_on = !last_stretch && $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 7))
               0:       write_register(CSR_VERTEX_TOTAL, 11'd0);
               1:       write_register(CSR_VERTEX_TOTAL, 11'd1);
               2:       write_register(CSR_VERTEX_TOTAL, 11'd1024);
               3:       write_register(CSR_VERTEX_TOTAL, 11'd2047);
               4:       write_register(CSR_VERTEX_TOTAL, $urandom_range(1, 2047));
               default: write_register(CSR_VERTEX_TOTAL, $urandom_range(2, 20));
            endcase
         end
         if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 5))
               0:       write_register(CSR_CORNERS_PER_FACE, 11'd3);
               1:       write_register(CSR_CORNERS_PER_FACE, 11'd4);
               2:       write_register(CSR_CORNERS_PER_FACE, 11'd6);
               3:       write_register(CSR_CORNERS_PER_FACE, 11'd8);
               default: write_register(CSR_CORNERS_PER_FACE, $urandom_range(0, 15));
            endcase
         end
         // Without a clear the next mesh lands on top of the stored corners.
         if ($urandom_range(0, 3) == 0 || mesh_corner_count > 600)
            send_request(FUNC_CLEAR, 0, 0);
         nv = active_vertices();
         if ($urandom_range(0, 9) == 0) corners = active_corners() * $urandom_range(40, 120);
         else corners = active_corners() * $urandom_range(0, 10);
         for (int i = 0; i < corners; i++) begin
            if (nv == 0 || $urandom_range(0, 24) == 0) vtx = VERT_W'($urandom_range(0, 1023));
            else vtx = VERT_W'($urandom_range(0, nv - 1));
            send_request(FUNC_APPEND, vtx, $urandom_range(0, 8191));
         end
         if ($urandom_range(0, 5) == 0)
            send_request(FUNC_READ_OFF, 0, $urandom_range(0, nv));
         send_request(FUNC_BUILD, $urandom_range(0, 1023), $urandom_range(0, 8191));
         reads = $urandom_range(2, 16);
         for (int k = 0; k < reads; k++) begin
            top = table_ready ? row_start[nv] : mesh_corner_count;
            case ($urandom_range(0, 11))
               0: send_request($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST),
                     $urandom_range(0, 1023), $urandom_range(0, 8191));
               1, 2, 3, 4: begin
                  case ($urandom_range(0, 5))
                     0:       idx = nv + 1;
                     1:       idx = $urandom_range(0, 8191);
                     default: idx = $urandom_range(0, nv);
                  endcase
                  send_request(FUNC_READ_OFF, $urandom_range(0, 1023), idx);
               end
               default: begin
                  case ($urandom_range(0, 7))
                     0:       idx = top;
                     1:       idx = $urandom_range(0, 8191);
                     default: idx = (top != 0) ? $urandom_range(0, top - 1) : 0;
                  endcase
                  send_request(FUNC_READ_ADJ, $urandom_range(0, 1023), idx);
               end
            endcase
         end
      end
   endtask

   // Result sink: short random stalls, or one long hold-off when asked.
   initial begin : reply_sink
      int burst;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            burst = $urandom_range(1, 6);
            repeat (burst) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      adj_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: reply: expected none, actual value %0d status %0d", $time,
                  rsp_tdata[VALUE_W-1:0], rsp_tuser);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tdata[VALUE_W-1:0] !== want.value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: func %0d value: expected %0d, actual %0d", $time,
                     want.code, want.value, rsp_tdata[VALUE_W-1:0]);
            end
            if (rsp_tuser !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: func %0d status: expected %0d, actual %0d", $time,
                     want.code, want.status, rsp_tuser);
            end
         end
      end
   end

   // Counts cycles without any transfer; a long clear or build stays well inside it.
   always @(posedge clock) begin
      int unsigned quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_register_limits();
      test_output_backpressure();
      test_store_full();
      test_random_meshes(1250);
      drain_replies();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/vfab_pkg.sv
rtl/core/vfab_ram.sv
rtl/core/vfab_ctrl.sv
rtl/core/vfab_dp.sv
rtl/core/vertex_face_adjacency_builder.sv
tb/sv/tb_vertex_face_adjacency_builder.sv
